// ===== hw/rtl/button_autorepeat_tracker_top_defines.svh =====
// Assertion macros used by the tracker controller RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef BUTTON_AUTOREPEAT_TRACKER_TOP_DEFINES_SVH
`define BUTTON_AUTOREPEAT_TRACKER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BAT_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tracker assertion failed: same-cycle check");

// Consequent must hold in the cycle after the antecedent.
`define BAT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tracker assertion failed: next-cycle check");

`endif

// ===== hw/rtl/bat_pkg.sv =====
package bat_pkg;

  // Channel count; it sets the pin field width and must fit the channel field.
  localparam int CHANNELS = 11;
  localparam int IDX_W    = $clog2(CHANNELS);
  localparam int TOTAL_W  = $clog2(CHANNELS + 1);

  // Field widths.
  localparam int OP_W     = 2;
  localparam int CH_W     = 4;
  localparam int MASK_W   = 3;
  localparam int TIME_W   = 32;
  localparam int HOLD_W   = 16;
  localparam int CNT_W    = 32;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_HIGH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DETECT      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_DELAY = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT      = 3'd4;

  // Register reset values.
  localparam logic [HOLD_W-1:0] DETECT_RESET      = 16'd60;
  localparam logic [HOLD_W-1:0] FIRST_DELAY_RESET = 16'd250;
  localparam logic [HOLD_W-1:0] REPEAT_RESET      = 16'd200;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Clear mask bits of a read.
  localparam int CLR_PRESS   = 0;
  localparam int CLR_RELEASE = 1;
  localparam int CLR_REPEAT  = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_READ,
    ST_CLEAR,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic tick_step;
    logic read_step;
    logic clear_all;
    logic load_out;
  } cmd_t;

endpackage

// ===== hw/rtl/bat_in_if.sv =====
interface bat_in_if import bat_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [CHANNELS-1:0] pin_levels;
  logic [TIME_W-1:0]   now_ms;
  logic [CH_W-1:0]     channel;
  logic [MASK_W-1:0]   clear_mask;

  modport source (output valid, op, pin_levels, now_ms, channel, clear_mask,
                  input ready);
  modport sink (input valid, op, pin_levels, now_ms, channel, clear_mask,
                output ready);
endinterface

// ===== hw/rtl/bat_out_if.sv =====
interface bat_out_if import bat_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               is_pressed;
  logic               is_released;
  logic               press_event;
  logic               release_event;
  logic [CNT_W-1:0]   repeat_event;
  logic [CNT_W-1:0]   repeat_count;
  logic [TIME_W-1:0]  press_duration;
  logic [TIME_W-1:0]  release_duration;
  logic [TOTAL_W-1:0] pressed_total;

  modport source (output valid, is_pressed, is_released, press_event, release_event,
                  repeat_event, repeat_count, press_duration, release_duration,
                  pressed_total, input ready);
  modport sink (input valid, is_pressed, is_released, press_event, release_event,
                repeat_event, repeat_count, press_duration, release_duration,
                pressed_total, output ready);
endinterface

// ===== hw/rtl/bat_dp.sv =====
module bat_dp import bat_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  cmd_t                   cmd,
  input  logic [IDX_W-1:0]       idx,
  input  logic [OP_W-1:0]        in_op,
  input  logic [CHANNELS-1:0]    in_pin_levels,
  input  logic [TIME_W-1:0]      in_now_ms,
  input  logic [CH_W-1:0]        in_channel,
  input  logic [MASK_W-1:0]      in_clear_mask,
  output logic                   is_pressed,
  output logic                   is_released,
  output logic                   press_event,
  output logic                   release_event,
  output logic [CNT_W-1:0]       repeat_event,
  output logic [CNT_W-1:0]       repeat_count,
  output logic [TIME_W-1:0]      press_duration,
  output logic [TIME_W-1:0]      release_duration,
  output logic [TOTAL_W-1:0]     pressed_total
);

  // Configuration registers.
  logic                enable;
  logic [CHANNELS-1:0] active_high;
  logic [HOLD_W-1:0]   detect_ticks;
  logic [HOLD_W-1:0]   first_delay_ticks;
  logic [HOLD_W-1:0]   repeat_ticks;

  // Per-channel state.
  logic [CHANNELS-1:0] pressed;
  logic [CHANNELS-1:0] released;
  logic [CHANNELS-1:0] press_edge;
  logic [CHANNELS-1:0] release_edge;
  logic [CHANNELS-1:0] pending;
  logic [HOLD_W-1:0]   hold [CHANNELS];
  logic [CNT_W-1:0]    rcnt [CHANNELS];
  logic [TIME_W-1:0]   press_start [CHANNELS];
  logic [TIME_W-1:0]   press_end [CHANNELS];
  logic [TIME_W-1:0]   release_start [CHANNELS];
  logic [TIME_W-1:0]   release_end [CHANNELS];

  // Captured item.
  logic [CHANNELS-1:0] levels_q;
  logic [TIME_W-1:0]   now_q;
  logic [CH_W-1:0]     channel_q;
  logic [MASK_W-1:0]   mask_q;

  // Result staging.
  logic               res_pressed;
  logic               res_released;
  logic               res_press_ev;
  logic               res_release_ev;
  logic [CNT_W-1:0]   res_repeat_ev;
  logic [CNT_W-1:0]   res_repeat_cnt;
  logic [TIME_W-1:0]  res_press_dur;
  logic [TIME_W-1:0]  res_release_dur;

  // Tick step for the channel under the walk index.
  logic              tk_press;
  logic [HOLD_W-1:0] tk_hold_inc;
  logic [HOLD_W-1:0] tk_thr;
  logic              tk_fire;

  always_comb begin
    tk_press    = (levels_q[idx] == active_high[idx]);
    tk_hold_inc = hold[idx] + HOLD_W'(1);
    if (rcnt[idx] == CNT_W'(0)) begin
      tk_thr = detect_ticks;
    end else if (rcnt[idx] == CNT_W'(1)) begin
      tk_thr = first_delay_ticks;
    end else begin
      tk_thr = repeat_ticks;
    end
    tk_fire = (tk_hold_inc >= tk_thr);
  end

  // Read access is valid only when enabled and in range.
  logic             rd_ok;
  logic [IDX_W-1:0] rd_c;

  assign rd_ok = enable && (channel_q < CH_W'(CHANNELS));
  assign rd_c  = channel_q[IDX_W-1:0];

  // Count of pressed channels.
  logic [TOTAL_W-1:0] total;

  always_comb begin
    total = '0;
    for (int n = 0; n < CHANNELS; n++) begin
      total = total + TOTAL_W'(pressed[n]);
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable            <= 1'b1;
      active_high       <= '0;
      detect_ticks      <= DETECT_RESET;
      first_delay_ticks <= FIRST_DELAY_RESET;
      repeat_ticks      <= REPEAT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:      enable            <= cfg_data[0];
        CFG_ACTIVE_HIGH: active_high       <= cfg_data[CHANNELS-1:0];
        CFG_DETECT:      detect_ticks      <= cfg_data;
        CFG_FIRST_DELAY: first_delay_ticks <= cfg_data;
        CFG_REPEAT:      repeat_ticks      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item capture; the result staging starts out as zeros.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      levels_q  <= in_pin_levels;
      now_q     <= in_now_ms;
      channel_q <= in_channel;
      mask_q    <= in_clear_mask;
    end
  end

  // Op code is decoded by the controller; it is kept here only for the read gate.
  logic read_item;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      read_item <= (in_op == OP_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_pressed     <= 1'b0;
      res_released    <= 1'b0;
      res_press_ev    <= 1'b0;
      res_release_ev  <= 1'b0;
      res_repeat_ev   <= '0;
      res_repeat_cnt  <= '0;
      res_press_dur   <= '0;
      res_release_dur <= '0;
    end else if (cmd.read_step && read_item && rd_ok) begin
      res_pressed     <= pressed[rd_c];
      res_released    <= released[rd_c];
      res_press_ev    <= press_edge[rd_c];
      res_release_ev  <= release_edge[rd_c];
      res_repeat_ev   <= pending[rd_c] ? rcnt[rd_c] : '0;
      res_repeat_cnt  <= rcnt[rd_c];
      res_press_dur   <= press_end[rd_c] - press_start[rd_c];
      res_release_dur <= release_end[rd_c] - release_start[rd_c];
    end
  end

  // Channel state: tick walk, read clears and the clear sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      pressed      <= '0;
      released     <= '0;
      press_edge   <= '0;
      release_edge <= '0;
      pending      <= '0;
      for (int n = 0; n < CHANNELS; n++) begin
        hold[n]          <= '0;
        rcnt[n]          <= '0;
        press_start[n]   <= '0;
        press_end[n]     <= '0;
        release_start[n] <= '0;
        release_end[n]   <= '0;
      end
    end else if (cmd.tick_step) begin
      if (tk_press) begin
        if (!pressed[idx]) begin
          press_edge[idx]  <= 1'b1;
          press_start[idx] <= now_q;
        end
        pressed[idx] <= 1'b1;
        if (tk_fire) begin
          hold[idx]    <= '0;
          rcnt[idx]    <= rcnt[idx] + CNT_W'(1);
          pending[idx] <= 1'b1;
        end else begin
          hold[idx] <= tk_hold_inc;
        end
        press_end[idx] <= now_q;
        released[idx]  <= 1'b0;
      end else begin
        if (pressed[idx]) begin
          release_edge[idx]  <= 1'b1;
          release_start[idx] <= now_q;
        end
        pressed[idx]     <= 1'b0;
        released[idx]    <= 1'b1;
        rcnt[idx]        <= '0;
        pending[idx]     <= 1'b0;
        release_end[idx] <= now_q;
      end
    end else if (cmd.read_step && read_item && rd_ok) begin
      if (mask_q[CLR_PRESS]) begin
        press_edge[rd_c] <= 1'b0;
      end
      if (mask_q[CLR_RELEASE]) begin
        release_edge[rd_c] <= 1'b0;
      end
      if (mask_q[CLR_REPEAT]) begin
        pending[rd_c] <= 1'b0;
      end
    end else if (cmd.clear_all) begin
      press_edge   <= '0;
      release_edge <= '0;
      for (int n = 0; n < CHANNELS; n++) begin
        press_start[n]   <= '0;
        press_end[n]     <= '0;
        release_start[n] <= '0;
        release_end[n]   <= '0;
      end
    end
  end

  // Output register, loaded once the item's work is done.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      is_pressed       <= res_pressed;
      is_released      <= res_released;
      press_event      <= res_press_ev;
      release_event    <= res_release_ev;
      repeat_event     <= res_repeat_ev;
      repeat_count     <= res_repeat_cnt;
      press_duration   <= res_press_dur;
      release_duration <= res_release_dur;
      pressed_total    <= enable ? total : '0;
    end
  end

endmodule

// ===== hw/rtl/bat_ctrl.sv =====
`include "button_autorepeat_tracker_top_defines.svh"

module bat_ctrl import bat_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [OP_W-1:0]  in_op,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output cmd_t             cmd,
  output logic [IDX_W-1:0] idx
);

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] idx_next;
  logic             out_valid_next;
  logic             slot_free;

  assign slot_free = !out_valid || out_ready;

  // State, walk index and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    idx_next   = idx;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        idx_next    = '0;
        if (in_valid) begin
          case (in_op)
            OP_TICK:  state_next = ST_TICK;
            OP_READ:  state_next = ST_READ;
            OP_CLEAR: state_next = ST_CLEAR;
            default:  state_next = ST_EMIT;
          endcase
        end
      end
      ST_TICK: begin
        cmd.tick_step = 1'b1;
        if (idx == IDX_W'(CHANNELS - 1)) begin
          state_next = ST_EMIT;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      ST_READ: begin
        cmd.read_step = 1'b1;
        state_next    = ST_EMIT;
      end
      ST_CLEAR: begin
        cmd.clear_all = 1'b1;
        state_next    = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // The output register holds one beat until the sink takes it.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  `BAT_ASSERT_SAME(a_load_into_free_slot, cmd.load_out, !out_valid || out_ready)
  `BAT_ASSERT_SAME(a_walk_in_range, state == ST_TICK, idx <= IDX_W'(CHANNELS - 1))
  `BAT_ASSERT_NEXT(a_accept_starts_work, in_valid && in_ready, state != ST_IDLE)
  `BAT_ASSERT_NEXT(a_load_shows_beat, cmd.load_out, out_valid)

endmodule

// ===== hw/rtl/button_autorepeat_tracker_top.sv =====
// Auto-repeat button tracker for CHANNELS buttons.
// Input channel din carries one item per beat: a tick (pin levels and time
// stamp), a channel read with a clear mask, or a clear of events and times.
// Every accepted item yields exactly one beat on dout; only reads carry
// channel data; each beat has the pressed channel count, zero if disabled.
// A tick walks the channels one per cycle in ST_TICK and then loads its
// result in ST_EMIT; a read or clear passes through ST_READ or ST_CLEAR
// before ST_EMIT, and an unused op code goes straight to ST_EMIT. One item
// is in work at a time; din is ready again the cycle after the result is
// loaded into the output register.
// The output register lets a new item be accepted and processed while the
// previous result beat is still waiting; if dout stays stalled, the finished
// item waits in its last state and din stays low until the register frees.
// Configuration writes (cfg_we, cfg_index, cfg_data) are taken in any cycle,
// apply from the next item, and must be made while the block is idle.
// Synchronous reset clears all channel state and loads the register defaults.
module button_autorepeat_tracker_top import bat_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  bat_in_if.sink                 din,
  bat_out_if.source              dout,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cmd_t             cmd;
  logic [IDX_W-1:0] idx;

  bat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_op     (din.op),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .cmd       (cmd),
    .idx       (idx)
  );

  bat_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .idx              (idx),
    .in_op            (din.op),
    .in_pin_levels    (din.pin_levels),
    .in_now_ms        (din.now_ms),
    .in_channel       (din.channel),
    .in_clear_mask    (din.clear_mask),
    .is_pressed       (dout.is_pressed),
    .is_released      (dout.is_released),
    .press_event      (dout.press_event),
    .release_event    (dout.release_event),
    .repeat_event     (dout.repeat_event),
    .repeat_count     (dout.repeat_count),
    .press_duration   (dout.press_duration),
    .release_duration (dout.release_duration),
    .pressed_total    (dout.pressed_total)
  );

endmodule

// ===== dv/button_autorepeat_tracker_top_test.sv =====
module button_autorepeat_tracker_top_test;
  import bat_pkg::*;

  // Op code the block leaves unused.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [MASK_W-1:0] MASK_NONE    = '0;
  localparam logic [MASK_W-1:0] MASK_ALL     = '1;
  localparam logic [MASK_W-1:0] MASK_PRESS   = MASK_W'(1) << CLR_PRESS;
  localparam logic [MASK_W-1:0] MASK_RELEASE = MASK_W'(1) << CLR_RELEASE;
  localparam logic [MASK_W-1:0] MASK_REPEAT  = MASK_W'(1) << CLR_REPEAT;

  localparam logic [CHANNELS-1:0] PINS_LOW  = '0;
  localparam logic [CHANNELS-1:0] PINS_HIGH = '1;

  // A tick walks all channels, so allow a little more than its latency.
  localparam int SETTLE_CYCLES = 20;
  localparam int STALL_LIMIT   = 2000;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [CHANNELS-1:0] pin_levels;
    logic [TIME_W-1:0]   now_ms;
    logic [CH_W-1:0]     channel;
    logic [MASK_W-1:0]   clear_mask;
  } button_item_t;

  typedef struct packed {
    logic               is_pressed;
    logic               is_released;
    logic               press_event;
    logic               release_event;
    logic [CNT_W-1:0]   repeat_event;
    logic [CNT_W-1:0]   repeat_count;
    logic [TIME_W-1:0]  press_duration;
    logic [TIME_W-1:0]  release_duration;
    logic [TOTAL_W-1:0] pressed_total;
  } channel_status_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_BURSTY} rx_mode_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  bat_in_if  din();
  bat_out_if dout();

  button_autorepeat_tracker_top dut (
    .clk       (clk),
    .rst       (rst),
    .din       (din),
    .dout      (dout),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Tracker registers as the testbench believes them to be.
  logic                cfg_en;
  logic [CHANNELS-1:0] cfg_active_high;
  logic [HOLD_W-1:0]   cfg_detect;
  logic [HOLD_W-1:0]   cfg_first_delay;
  logic [HOLD_W-1:0]   cfg_repeat;

  // Per-channel tracker state.
  logic [CHANNELS-1:0] pressed;
  logic [CHANNELS-1:0] released;
  logic [CHANNELS-1:0] press_ev;
  logic [CHANNELS-1:0] release_ev;
  logic [CHANNELS-1:0] rpt_pending;
  logic [HOLD_W-1:0]   hold_cnt    [CHANNELS];
  logic [CNT_W-1:0]    rpt_cnt     [CHANNELS];
  logic [TIME_W-1:0]   press_start [CHANNELS];
  logic [TIME_W-1:0]   press_end   [CHANNELS];
  logic [TIME_W-1:0]   rel_start   [CHANNELS];
  logic [TIME_W-1:0]   rel_end     [CHANNELS];

  channel_status_t status_queue[$];
  int error_count;
  int idle_cycles;
  int burst_left;
  bit sender_steady;

  // Slowly changing pin picture and clock used by well-formed tick sequences.
  logic [CHANNELS-1:0] held_pins;
  logic [TIME_W-1:0]   sim_now;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Return the tracker to its reset state.
  function automatic void reset_tracker();
    cfg_en          = 1'b1;
    cfg_active_high = '0;
    cfg_detect      = DETECT_RESET;
    cfg_first_delay = FIRST_DELAY_RESET;
    cfg_repeat      = REPEAT_RESET;
    pressed         = '0;
    released        = '0;
    press_ev        = '0;
    release_ev      = '0;
    rpt_pending     = '0;
    for (int n = 0; n < CHANNELS; n++) begin
      hold_cnt[n]    = '0;
      rpt_cnt[n]     = '0;
      press_start[n] = '0;
      press_end[n]   = '0;
      rel_start[n]   = '0;
      rel_end[n]     = '0;
    end
  endfunction

  // Apply one item to the tracker state and return the status beat it yields.
  function automatic channel_status_t advance_tracker(input button_item_t it);
    channel_status_t s;
    logic [HOLD_W-1:0] thr;
    int c;
    s = '0;
    case (it.op)
      OP_TICK: begin
        for (int n = 0; n < CHANNELS; n++) begin
          if (it.pin_levels[n] == cfg_active_high[n]) begin
            if (!pressed[n]) begin
              press_ev[n]    = 1'b1;
              press_start[n] = it.now_ms;
            end
            pressed[n]  = 1'b1;
            hold_cnt[n] = hold_cnt[n] + 1'b1;
            // Detect, then first delay, then the steady repeat interval.
            if (rpt_cnt[n] == 0) thr = cfg_detect;
            else if (rpt_cnt[n] == 1) thr = cfg_first_delay;
            else thr = cfg_repeat;
            if (hold_cnt[n] >= thr) begin
              hold_cnt[n]    = '0;
              rpt_cnt[n]     = rpt_cnt[n] + 1'b1;
              rpt_pending[n] = 1'b1;
            end
            press_end[n] = it.now_ms;
            released[n]  = 1'b0;
          end else begin
            // Release keeps the hold count; only the repeat count restarts.
            if (pressed[n]) begin
              release_ev[n] = 1'b1;
              rel_start[n]  = it.now_ms;
            end
            pressed[n]     = 1'b0;
            released[n]    = 1'b1;
            rpt_cnt[n]     = '0;
            rpt_pending[n] = 1'b0;
            rel_end[n]     = it.now_ms;
          end
        end
      end
      OP_READ: begin
        if (cfg_en && it.channel < CHANNELS) begin
          c = int'(it.channel);
          s.is_pressed       = pressed[c];
          s.is_released      = released[c];
          s.press_event      = press_ev[c];
          s.release_event    = release_ev[c];
          s.repeat_event     = rpt_pending[c] ? rpt_cnt[c] : '0;
          s.repeat_count     = rpt_cnt[c];
          s.press_duration   = press_end[c] - press_start[c];
          s.release_duration = rel_end[c] - rel_start[c];
          if (it.clear_mask[CLR_PRESS]) press_ev[c] = 1'b0;
          if (it.clear_mask[CLR_RELEASE]) release_ev[c] = 1'b0;
          if (it.clear_mask[CLR_REPEAT]) rpt_pending[c] = 1'b0;
        end
      end
      OP_CLEAR: begin
        for (int n = 0; n < CHANNELS; n++) begin
          press_start[n] = '0;
          press_end[n]   = '0;
          rel_start[n]   = '0;
          rel_end[n]     = '0;
        end
        press_ev   = '0;
        release_ev = '0;
      end
      default: ;
    endcase
    if (cfg_en) s.pressed_total = TOTAL_W'($countones(pressed));
    return s;
  endfunction

  function automatic button_item_t tick_item(input logic [CHANNELS-1:0] pins,
                                             input logic [TIME_W-1:0] now);
    button_item_t it;
    it = '0;
    it.op         = OP_TICK;
    it.pin_levels = pins;
    it.now_ms     = now;
    return it;
  endfunction

  function automatic button_item_t read_item(input logic [CH_W-1:0] ch,
                                             input logic [MASK_W-1:0] mask);
    button_item_t it;
    it = '0;
    it.op         = OP_READ;
    it.channel    = ch;
    it.clear_mask = mask;
    return it;
  endfunction

  function automatic button_item_t plain_item(input logic [OP_W-1:0] op);
    button_item_t it;
    it = '0;
    it.op = op;
    return it;
  endfunction

  // Mostly held buttons with a rising clock, plus reads, clears and noise.
  function automatic button_item_t random_item();
    button_item_t it;
    int pick;
    int k;
    it.op         = OP_TICK;
    it.pin_levels = CHANNELS'($urandom);
    it.now_ms     = TIME_W'($urandom);
    it.channel    = CH_W'($urandom);
    it.clear_mask = MASK_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      if ($urandom_range(0, 3) == 0) begin
        k = $urandom_range(0, CHANNELS - 1);
        held_pins[k] = ~held_pins[k];
      end
      if ($urandom_range(0, 49) == 0) held_pins = CHANNELS'($urandom);
      sim_now = sim_now + TIME_W'($urandom_range(1, 20));
      if ($urandom_range(0, 99) == 0) sim_now = TIME_W'($urandom);
      it.pin_levels = held_pins;
      it.now_ms     = sim_now;
    end else if (pick < 90) begin
      it.op = OP_READ;
      if ($urandom_range(0, 9) == 0) it.channel = CH_W'($urandom_range(CHANNELS, 15));
      else it.channel = CH_W'($urandom_range(0, CHANNELS - 1));
    end else if (pick < 94) begin
      it.op = OP_CLEAR;
    end else if (pick < 96) begin
      it.op = OP_UNUSED;
    end
    // The remainder stays a tick with fully random pins and time stamp.
    return it;
  endfunction

  // Drive one item until its beat is taken, then maybe open a gap.
  task automatic send_item(input button_item_t it);
    din.valid      <= 1'b1;
    din.op         <= it.op;
    din.pin_levels <= it.pin_levels;
    din.now_ms     <= it.now_ms;
    din.channel    <= it.channel;
    din.clear_mask <= it.clear_mask;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
    status_queue.push_back(advance_tracker(it));
    if (!sender_steady) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 12);
        if ($urandom_range(0, 3) != 0) begin
          din.valid <= 1'b0;
          repeat ($urandom_range(1, 10)) @(posedge clk);
        end
      end
    end
  endtask

  // Stop offering items and wait for every outstanding result beat.
  task automatic wait_drained();
    if (din.valid) din.valid <= 1'b0;
    while (status_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ENABLE:      cfg_en          = data[0];
      CFG_ACTIVE_HIGH: cfg_active_high = data[CHANNELS-1:0];
      CFG_DETECT:      cfg_detect      = data;
      CFG_FIRST_DELAY: cfg_first_delay = data;
      CFG_REPEAT:      cfg_repeat      = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Defaults after reset: active-low pins, time stamps across the wrap, odd channels.
  task automatic test_directed_basics();
    send_item(tick_item(PINS_LOW, 32'hFFFF_FFF0));
    send_item(tick_item(PINS_LOW, 32'h0000_0005));
    send_item(read_item(4'd0, MASK_NONE));
    send_item(read_item(4'd10, MASK_ALL));
    send_item(read_item(4'd10, MASK_NONE));
    send_item(tick_item(PINS_HIGH, 32'hFFFF_FFFF));
    send_item(read_item(4'd11, MASK_ALL));
    send_item(read_item(4'd15, MASK_ALL));
    send_item(read_item(4'd3, MASK_RELEASE));
    send_item(plain_item(OP_CLEAR));
    send_item(read_item(4'd3, MASK_NONE));
    send_item(plain_item(OP_UNUSED));
  endtask

  // Zero thresholds fire a repeat on every held tick.
  task automatic test_zero_thresholds();
    wait_drained();
    write_reg(CFG_ACTIVE_HIGH, CFG_DATA_W'(PINS_HIGH));
    write_reg(CFG_DETECT, '0);
    write_reg(CFG_FIRST_DELAY, '0);
    write_reg(CFG_REPEAT, '0);
    send_item(tick_item(PINS_HIGH, 32'd100));
    send_item(tick_item(PINS_HIGH, 32'd110));
    send_item(tick_item(PINS_HIGH, 32'd120));
    send_item(read_item(4'd5, MASK_REPEAT));
    send_item(read_item(4'd5, MASK_PRESS));
  endtask

  // Disabled reads return zeros and clear nothing, while ticks still count.
  task automatic test_disabled_reads();
    wait_drained();
    write_reg(CFG_ENABLE, '0);
    send_item(tick_item(PINS_LOW, 32'd200));
    send_item(read_item(4'd0, MASK_ALL));
    send_item(tick_item(PINS_HIGH, 32'd210));
    wait_drained();
    write_reg(CFG_ENABLE, CFG_DATA_W'(1));
    send_item(read_item(4'd0, MASK_ALL));
    send_item(read_item(4'd0, MASK_NONE));
  endtask

  // One random phase under a fixed register setting, entered from idle.
  task automatic run_holds_phase(input logic en, input logic [CHANNELS-1:0] ah,
                                 input logic [HOLD_W-1:0] det,
                                 input logic [HOLD_W-1:0] first,
                                 input logic [HOLD_W-1:0] rep,
                                 input int count, input bit steady);
    wait_drained();
    write_reg(CFG_ENABLE, CFG_DATA_W'(en));
    write_reg(CFG_ACTIVE_HIGH, CFG_DATA_W'(ah));
    write_reg(CFG_DETECT, det);
    write_reg(CFG_FIRST_DELAY, first);
    write_reg(CFG_REPEAT, rep);
    sender_steady = steady;
    for (int i = 0; i < count; i++) send_item(random_item());
    sender_steady = 1'b0;
  endtask

  task automatic test_random_holds();
    run_holds_phase(1'b1, CHANNELS'($urandom), 16'd2, 16'd3, 16'd1, 250, 1'b0);
    run_holds_phase(1'b1, PINS_LOW, 16'd0, 16'd1, 16'd0, 200, 1'b1);
    run_holds_phase(1'b1, PINS_HIGH, 16'd5, 16'd9, 16'd4, 250, 1'b0);
    run_holds_phase(1'b0, CHANNELS'($urandom), 16'd3, 16'd2, 16'd2, 100, 1'b0);
    run_holds_phase(1'b1, CHANNELS'($urandom), DETECT_RESET, FIRST_DELAY_RESET,
                    REPEAT_RESET, 200, 1'b0);
    run_holds_phase(1'b1, CHANNELS'($urandom), 16'hFFFF, 16'hFFFF, 16'hFFFF, 100, 1'b1);
    run_holds_phase(1'b1, CHANNELS'($urandom), 16'd1, 16'hFFFF, 16'd1, 100, 1'b0);
  endtask

  // Result receiver: switches between open, random and bursty stall patterns.
  initial begin : out_ready_gen
    rx_mode_t mode;
    int mode_left;
    int run_left;
    logic rdy;
    mode      = RX_OPEN;
    mode_left = 0;
    run_left  = 0;
    rdy       = 1'b0;
    dout.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      case (mode)
        RX_OPEN:   rdy = 1'b1;
        RX_RANDOM: rdy = 1'($urandom_range(0, 1));
        default: begin
          if (run_left == 0) begin
            rdy      = ~rdy;
            run_left = rdy ? $urandom_range(1, 4) : $urandom_range(1, 12);
          end
          run_left--;
        end
      endcase
      dout.ready <= rdy;
    end
  end

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      error_count++;
    end
  endfunction

  // Compare each result beat against the oldest prediction; watch for a hang.
  always @(posedge clk) begin : result_check
    channel_status_t want;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if ((din.valid && din.ready) || (dout.valid && dout.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (dout.valid && dout.ready) begin
        if (status_queue.size() == 0) begin
          $error("result beat with no item outstanding");
          error_count++;
        end else begin
          want = status_queue.pop_front();
          check_field("is_pressed", want.is_pressed, dout.is_pressed);
          check_field("is_released", want.is_released, dout.is_released);
          check_field("press_event", want.press_event, dout.press_event);
          check_field("release_event", want.release_event, dout.release_event);
          check_field("repeat_event", want.repeat_event, dout.repeat_event);
          check_field("repeat_count", want.repeat_count, dout.repeat_count);
          check_field("press_duration", want.press_duration, dout.press_duration);
          check_field("release_duration", want.release_duration, dout.release_duration);
          check_field("pressed_total", want.pressed_total, dout.pressed_total);
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("button_autorepeat_tracker_top_test: FAIL");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = CFG_ENABLE;
    cfg_data       = '0;
    din.valid      = 1'b0;
    din.op         = OP_TICK;
    din.pin_levels = '0;
    din.now_ms     = '0;
    din.channel    = '0;
    din.clear_mask = '0;
    error_count    = 0;
    burst_left     = $urandom_range(1, 12);
    sender_steady  = 1'b0;
    held_pins      = CHANNELS'($urandom);
    sim_now        = TIME_W'($urandom);
    reset_tracker();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_directed_basics();
    test_zero_thresholds();
    test_disabled_reads();
    test_random_holds();

    wait_drained();
    if (error_count == 0) $display("button_autorepeat_tracker_top_test: PASS");
    else $display("button_autorepeat_tracker_top_test: FAIL");
    $finish;
  end

endmodule
